FILE: src/dss_pkg.sv
package dss_pkg;

    localparam int ENTRIES = 16;
    localparam int KEY_W   = 30;
    localparam int TAG_W   = 4;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } entry_t;

    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctl_t;

endpackage

FILE: src/dss_cell.sv
module dss_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  dss_pkg::cell_ctl_t        ctl,
    input  logic [dss_pkg::KEY_W-1:0] new_key,
    input  logic [dss_pkg::TAG_W-1:0] new_tag,
    input  dss_pkg::entry_t           prev_entry,
    input  logic                      prev_ins,
    input  dss_pkg::entry_t           next_entry,
    output dss_pkg::entry_t           entry,
    output logic                      ins
);

    logic                      valid_reg;
    logic                      valid_next;
    logic [dss_pkg::KEY_W-1:0] key_reg;
    logic [dss_pkg::KEY_W-1:0] key_next;
    logic [dss_pkg::TAG_W-1:0] tag_reg;
    logic [dss_pkg::TAG_W-1:0] tag_next;

    // new entry goes above this cell when the cell is empty or holds a smaller key
    assign ins = !valid_reg || (new_key > key_reg);

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        tag_next   = tag_reg;
        if (ctl.load && ins)
        begin
            if (prev_ins)
            begin
                valid_next = prev_entry.valid;
                key_next   = prev_entry.key;
                tag_next   = prev_entry.tag;
            end
            else
            begin
                valid_next = 1'b1;
                key_next   = new_key;
                tag_next   = new_tag;
            end
        end
        else if (ctl.shift)
        begin
            valid_next = next_entry.valid;
            key_next   = next_entry.key;
            tag_next   = next_entry.tag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        tag_reg <= tag_next;
    end

    assign entry.valid = valid_reg;
    assign entry.key   = key_reg;
    assign entry.tag   = tag_reg;

endmodule

FILE: src/descending_stable_sorter.sv
// Insertion sorter for batches of up to 16 key/tag entries. Entries are taken one beat
// per cycle into a chain of cells that keeps the batch ordered by key, greatest first,
// with equal keys in arrival order. A batch closes on a beat with batch_end set or on
// the beat that fills the chain; the chain then shifts toward its head one entry per
// output beat, the last marked with run_end. Input is stalled while a batch drains.
module descending_stable_sorter (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [dss_pkg::KEY_W-1:0] sort_key,
    input  logic [dss_pkg::TAG_W-1:0] entry_tag,
    input  logic                      batch_end,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [dss_pkg::KEY_W-1:0] sorted_key,
    output logic [dss_pkg::TAG_W-1:0] sorted_tag,
    output logic                      run_end
);

    localparam logic ST_LOAD  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic state_reg;
    logic state_next;

    dss_pkg::entry_t             cells [dss_pkg::ENTRIES];
    logic [dss_pkg::ENTRIES-1:0] ins_vec;
    logic [dss_pkg::ENTRIES-1:0] valid_vec;
    dss_pkg::cell_ctl_t          ctl;
    dss_pkg::entry_t             empty_entry;

    logic load;
    logic shift;

    assign in_stall  = (state_reg == ST_DRAIN);
    assign out_valid = (state_reg == ST_DRAIN);
    assign load      = in_valid && !in_stall;
    assign shift     = out_valid && !out_stall;
    assign ctl.load  = load;
    assign ctl.shift = shift;

    assign empty_entry.valid = 1'b0;
    assign empty_entry.key   = '0;
    assign empty_entry.tag   = '0;

    genvar gi;
    generate
        for (gi = 0; gi < dss_pkg::ENTRIES; gi++)
        begin : g_cell
            dss_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .new_key    (sort_key),
                .new_tag    (entry_tag),
                .prev_entry ((gi == 0) ? empty_entry : cells[(gi == 0) ? 0 : gi-1]),
                .prev_ins   ((gi == 0) ? 1'b0 : ins_vec[(gi == 0) ? 0 : gi-1]),
                .next_entry ((gi == dss_pkg::ENTRIES-1) ? empty_entry
                             : cells[(gi == dss_pkg::ENTRIES-1) ? gi : gi+1]),
                .entry      (cells[gi]),
                .ins        (ins_vec[gi])
            );
            assign valid_vec[gi] = cells[gi].valid;
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (load && (batch_end || cells[dss_pkg::ENTRIES-2].valid))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (shift && !cells[1].valid)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign sorted_key = cells[0].key;
    assign sorted_tag = cells[0].tag;
    assign run_end    = !cells[1].valid;

    // occupied cells form a prefix of the chain
    assert property (@(posedge clk) disable iff (!rst_n)
        ((valid_vec + 1'b1) & valid_vec) == '0)
        else $error("occupied cells not contiguous");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> cells[0].valid)
        else $error("drain with empty head cell");

    assert property (@(posedge clk) disable iff (!rst_n)
        cells[1].valid |-> (cells[0].key >= cells[1].key))
        else $error("head cells out of order");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD) |-> !cells[dss_pkg::ENTRIES-1].valid)
        else $error("chain full while loading");

    assert property (@(posedge clk) disable iff (!rst_n)
        (load && batch_end) |=> out_valid)
        else $error("closed batch did not start draining");

endmodule

FILE: verif/testbench.sv
module testbench;

    localparam logic [dss_pkg::KEY_W-1:0] KEY_MAX = '1;
    localparam int RANDOM_BEATS = 350;
    localparam int LONG_HOLD    = 150;

    typedef struct packed {
        logic [dss_pkg::KEY_W-1:0] key;
        logic [dss_pkg::TAG_W-1:0] tag;
        logic                      last;
    } sorted_res_t;

    typedef struct packed {
        logic [dss_pkg::KEY_W-1:0] key;
        logic [dss_pkg::TAG_W-1:0] tag;
        logic                      last;
        logic                      typed;
        logic [dss_pkg::KEY_W-1:0] want_key;
        logic [dss_pkg::TAG_W-1:0] want_tag;
        logic                      want_end;
    } stim_row_t;

    typedef enum int {KEYS_WIDE, KEYS_CLUSTERED, KEYS_EXTREME} key_spread_e;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      in_valid  = 1'b0;
    logic                      in_stall;
    logic [dss_pkg::KEY_W-1:0] sort_key  = '0;
    logic [dss_pkg::TAG_W-1:0] entry_tag = '0;
    logic                      batch_end = 1'b0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [dss_pkg::KEY_W-1:0] sorted_key;
    logic [dss_pkg::TAG_W-1:0] sorted_tag;
    logic                      run_end;

    logic [dss_pkg::KEY_W-1:0] held_key [dss_pkg::ENTRIES];
    logic [dss_pkg::TAG_W-1:0] held_tag [dss_pkg::ENTRIES];
    int                        held_count = 0;
    sorted_res_t               pending_sorted [$];

    int   send_gap_pct   = 0;
    int   recv_stall_pct = 0;
    int   results_seen   = 0;
    int   mismatch_count = 0;
    int   hold_left      = 0;
    logic hold_done      = 1'b0;

    // key, tag, batch_end, typed, expected key, expected tag, expected run_end
    stim_row_t directed_rows [25] = '{
        '{KEY_MAX,         4'd15, 1'b1, 1'b1, KEY_MAX, 4'd15, 1'b1},
        '{30'd0,           4'd0,  1'b1, 1'b1, 30'd0,   4'd0,  1'b1},
        '{30'd5,           4'd1,  1'b0, 1'b0, 30'd0,   4'd0,  1'b0},
        '{30'd5,           4'd2,  1'b0, 1'b0, 30'd0,   4'd0,  1'b0},
        '{30'd5,           4'd3,  1'b0, 1'b0, 30'd0,   4'd0,  1'b0},
        '{30'd5,           4'd4,  1'b1, 1'b0, 30'd0,   4'd0,  1'b0},
        '{30'd0,           4'd6,  1'b0, 1'b0, 30'd0,   4'd0,  1'b0},
        '{30'd1,           4'd7,  1'b0, 1'b0, 30'd0,   4'd0,  1'b0},
        '{KEY_MAX,         4'd8,  1'b1, 1'b0, 30'd0,   4'd0,  1'b0},
        '{30'h2AAAAAAA,    4'd0,  1'b0, 1'b0, 30'd0,   4'd0,  1'b0},
        '{30'h15555555,    4'd1,  1'b0, 1'b0, 30'd0,   4'd0,  1'b0},
        '{KEY_MAX,         4'd2,  1'b0, 1'b0, 30'd0,   4'd0,  1'b0},
        '{30'd0,           4'd3,  1'b0, 1'b0, 30'd0,   4'd0,  1'b0},
        '{30'd100,         4'd4,  1'b0, 1'b0, 30'd0,   4'd0,  1'b0},
        '{30'd100,         4'd5,  1'b0, 1'b0, 30'd0,   4'd0,  1'b0},
        '{30'd7,           4'd6,  1'b0, 1'b0, 30'd0,   4'd0,  1'b0},
        '{KEY_MAX,         4'd7,  1'b0, 1'b0, 30'd0,   4'd0,  1'b0},
        '{30'h20000000,    4'd8,  1'b0, 1'b0, 30'd0,   4'd0,  1'b0},
        '{30'd1,           4'd9,  1'b0, 1'b0, 30'd0,   4'd0,  1'b0},
        '{30'd100,         4'd10, 1'b0, 1'b0, 30'd0,   4'd0,  1'b0},
        '{30'h3FFFFFFE,    4'd11, 1'b0, 1'b0, 30'd0,   4'd0,  1'b0},
        '{30'd0,           4'd12, 1'b0, 1'b0, 30'd0,   4'd0,  1'b0},
        '{30'h15555555,    4'd13, 1'b0, 1'b0, 30'd0,   4'd0,  1'b0},
        '{30'd42,          4'd14, 1'b0, 1'b0, 30'd0,   4'd0,  1'b0},
        '{30'd42,          4'd15, 1'b0, 1'b0, 30'd0,   4'd0,  1'b0}
    };

    descending_stable_sorter uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sort_key   (sort_key),
        .entry_tag  (entry_tag),
        .batch_end  (batch_end),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sorted_key (sorted_key),
        .sorted_tag (sorted_tag),
        .run_end    (run_end)
    );

    always #10 clk = ~clk;

    // entry goes below every held entry with a key greater or equal
    function automatic void sort_in_entry(input logic [dss_pkg::KEY_W-1:0] k,
                                          input logic [dss_pkg::TAG_W-1:0] t,
                                          input logic e);
        int pos;
        if (held_count >= dss_pkg::ENTRIES)
            held_count = 0;
        pos = held_count;
        while (pos > 0 && held_key[pos-1] < k)
        begin
            held_key[pos] = held_key[pos-1];
            held_tag[pos] = held_tag[pos-1];
            pos--;
        end
        held_key[pos] = k;
        held_tag[pos] = t;
        held_count++;
        if (e || held_count == dss_pkg::ENTRIES)
        begin
            for (int i = 0; i < held_count; i++)
                pending_sorted.push_back(
                    sorted_res_t'{held_key[i], held_tag[i], i == held_count - 1});
            held_count = 0;
        end
    endfunction

    task automatic feed_entry(input logic [dss_pkg::KEY_W-1:0] k,
                              input logic [dss_pkg::TAG_W-1:0] t,
                              input logic e);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        sort_key  <= k;
        entry_tag <= t;
        batch_end <= e;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        if (!hold_done && results_seen >= 40)
        begin
            hold_left = LONG_HOLD;
            hold_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        sorted_res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (pending_sorted.size() == 0)
            begin
                $error("unexpected result beat key=%0h tag=%0h run_end=%0b",
                       sorted_key, sorted_tag, run_end);
                mismatch_count++;
            end
            else
            begin
                want = pending_sorted.pop_front();
                if (sorted_key !== want.key)
                begin
                    $error("sorted_key expected %0h actual %0h", want.key, sorted_key);
                    mismatch_count++;
                end
                if (sorted_tag !== want.tag)
                begin
                    $error("sorted_tag expected %0h actual %0h", want.tag, sorted_tag);
                    mismatch_count++;
                end
                if (run_end !== want.last)
                begin
                    $error("run_end expected %0b actual %0b", want.last, run_end);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        int                        random_sent;
        int                        batch_no;
        int                        batch_len;
        key_spread_e               spread;
        logic [dss_pkg::KEY_W-1:0] k;
        logic                      e;
        random_sent = 0;
        batch_no    = 0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            feed_entry(directed_rows[i].key, directed_rows[i].tag, directed_rows[i].last);
            if (directed_rows[i].typed)
                pending_sorted.push_back(sorted_res_t'{directed_rows[i].want_key,
                                                       directed_rows[i].want_tag,
                                                       directed_rows[i].want_end});
            else
                sort_in_entry(directed_rows[i].key, directed_rows[i].tag,
                              directed_rows[i].last);
        end

        while (random_sent < RANDOM_BEATS)
        begin
            case ((batch_no / 3) % 4)
                0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_gap_pct = 55; recv_stall_pct = 0;  end
                2: begin send_gap_pct = 0;  recv_stall_pct = 55; end
                default: begin send_gap_pct = 20; recv_stall_pct = 20; end
            endcase
            batch_len = ($urandom_range(3) == 0) ? dss_pkg::ENTRIES
                                                 : $urandom_range(1, dss_pkg::ENTRIES - 1);
            spread    = key_spread_e'($urandom_range(2));
            for (int i = 0; i < batch_len; i++)
            begin
                case (spread)
                    KEYS_WIDE:      k = dss_pkg::KEY_W'($urandom);
                    KEYS_CLUSTERED: k = dss_pkg::KEY_W'($urandom_range(7));
                    default:        k = $urandom_range(1)
                                        ? KEY_MAX - dss_pkg::KEY_W'($urandom_range(2))
                                        : dss_pkg::KEY_W'($urandom_range(2));
                endcase
                // a full batch closes with or without batch_end
                if (i == batch_len - 1)
                    e = (batch_len == dss_pkg::ENTRIES) ? 1'($urandom_range(1)) : 1'b1;
                else
                    e = 1'b0;
                feed_entry(k, dss_pkg::TAG_W'($urandom), e);
                sort_in_entry(k, entry_tag, e);
                random_sent++;
            end
            batch_no++;
        end

        in_valid <= 1'b0;
        while (pending_sorted.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("status: fail");
        $finish;
    end

endmodule
